/* hdl/pmco_pkg.sv */
package pmco_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 29;
  localparam int IDX_W    = 12;
  localparam int QCNT_W   = 4;
  localparam int MAX_QUB  = 12;
  localparam int ACC_W    = 66;
  localparam int MAG_W    = 64;
  localparam int QUO_W    = 61;
  localparam int DIV_STEPS = 64 + FRAC_W + 1;
  localparam int CNT_W    = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COND_VALUE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_REAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_IMAG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_REAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_IMAG = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_QUBIT_COUNT  = 3'd7;

  localparam logic [DATA_W-1:0] COEF_ONE = 32'h2000_0000;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL  = 3'd1,
    S_ACC  = 3'd2,
    S_DLD  = 3'd3,
    S_DIV  = 3'd4,
    S_FIN  = 3'd5
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       mul_go;
    logic [2:0] mul_sel;
    logic       div_load;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic coef_zero;
  } stat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } sat_t;

  localparam logic signed [ACC_W-1:0] SAT_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  function automatic sat_t sat_fn(input logic signed [ACC_W-1:0] x);
    sat_t s;
    if (x > SAT_HI) begin
      s.val  = SAT_HI[DATA_W-1:0];
      s.clip = 1'b1;
    end else if (x < SAT_LO) begin
      s.val  = SAT_LO[DATA_W-1:0];
      s.clip = 1'b1;
    end else begin
      s.val  = x[DATA_W-1:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

endpackage

/* hdl/pmco_ctrl.sv */
module pmco_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pmco_pkg::stat_t   stat,
  output pmco_pkg::cmd_t    cmd
);

  pmco_pkg::state_t               state_r, state_nxt;
  logic [pmco_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [pmco_pkg::CNT_W-1:0]     mul_last;

  assign mul_last = (stat.op == pmco_pkg::OP_MUL) ? 7'd3 : 7'd5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmco_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pmco_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          if (stat.op == pmco_pkg::OP_ADD || stat.op == pmco_pkg::OP_SUB) begin
            state_nxt = pmco_pkg::S_FIN;
          end else begin
            state_nxt = pmco_pkg::S_MUL;
          end
        end
      end
      pmco_pkg::S_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = cnt_r[2:0];
        if (cnt_r == mul_last) begin
          state_nxt = pmco_pkg::S_ACC;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      pmco_pkg::S_ACC: begin
        if (stat.op == pmco_pkg::OP_MUL) begin
          state_nxt = pmco_pkg::S_FIN;
        end else begin
          state_nxt = pmco_pkg::S_DLD;
        end
      end
      pmco_pkg::S_DLD: begin
        if (stat.coef_zero) begin
          state_nxt = pmco_pkg::S_FIN;
        end else begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = pmco_pkg::S_DIV;
        end
      end
      pmco_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == 7'(pmco_pkg::DIV_STEPS - 1)) begin
          state_nxt = pmco_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      pmco_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = pmco_pkg::S_IDLE;
        end
      end
      default: state_nxt = pmco_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != pmco_pkg::S_IDLE)
    else $error("accepted transaction did not start work");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pmco_pkg::S_DIV |-> cnt_r < 7'(pmco_pkg::DIV_STEPS))
    else $error("divide step count out of range");
`endif

endmodule

/* hdl/pmco_dpath.sv */
module pmco_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pmco_pkg::cmd_t                    cmd,
  output pmco_pkg::stat_t                   stat,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmco_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmco_pkg::DATA_W-1:0]       cfg_data,
  input  logic signed [pmco_pkg::DATA_W-1:0] in_element_real,
  input  logic signed [pmco_pkg::DATA_W-1:0] in_element_imag,
  input  logic                              in_start_of_matrix,
  output logic signed [pmco_pkg::DATA_W-1:0] out_result_real,
  output logic signed [pmco_pkg::DATA_W-1:0] out_result_imag,
  output logic [pmco_pkg::IDX_W-1:0]        out_row_index,
  output logic [pmco_pkg::IDX_W-1:0]        out_col_index,
  output logic                              out_last_element,
  output logic                              out_saturated,
  output logic                              out_divide_by_zero
);

  localparam int DW = pmco_pkg::DATA_W;
  localparam int AW = pmco_pkg::ACC_W;
  localparam int MW = pmco_pkg::MAG_W;
  localparam int QW = pmco_pkg::QUO_W;
  localparam int IW = pmco_pkg::IDX_W;

  // configuration
  logic [IW-1:0]          mask_r, cond_r;
  pmco_pkg::op_t          op_cfg_r;
  logic [DW-1:0]          sr_r, si_r, fr_r, fi_r;
  logic [pmco_pkg::QCNT_W-1:0] qcnt_r;

  // counters and latched transaction
  logic [IW-1:0]          row_r, col_r;
  logic [IW-1:0]          row_cur_r, col_cur_r;
  logic                   last_r;
  logic signed [DW-1:0]   ar_r, ai_r, cr_r, ci_r;
  pmco_pkg::op_t          op_r;
  logic                   czero_r;

  // products and sums
  logic signed [2*DW-1:0] p_r;
  logic [2:0]             psel_r;
  logic                   pv_r;
  logic signed [AW-1:0]   acc_re_r, acc_im_r;
  logic [MW-1:0]          d_r;

  // dividers
  logic [MW-1:0]          sh_re_r, sh_im_r, rem_re_r, rem_im_r;
  logic [QW-1:0]          q_re_r, q_im_r;
  logic                   big_re_r, big_im_r, neg_re_r, neg_im_r;

  logic [IW-1:0]          r_cur, c_cur, last_row;
  logic [pmco_pkg::QCNT_W-1:0] q_eff;
  logic                   last_cur, hit;
  logic signed [DW-1:0]   ma, mb;
  logic signed [AW-1:0]   pe;
  logic [MW:0]            rem2_re, rem2_im;
  logic                   ge_re, ge_im;
  logic [QW-1:0]          qn_re, qn_im;
  logic [QW-1:0]          qr_re, qr_im;
  logic signed [AW-1:0]   dv_re, dv_im, x_re, x_im, rnd_re, rnd_im;
  pmco_pkg::sat_t         s_re, s_im;

  assign cfg_ready = 1'b1;
  assign stat.op = op_cfg_r;
  assign stat.coef_zero = czero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      cond_r   <= '0;
      op_cfg_r <= pmco_pkg::OP_MUL;
      sr_r     <= pmco_pkg::COEF_ONE;
      si_r     <= '0;
      fr_r     <= pmco_pkg::COEF_ONE;
      fi_r     <= '0;
      qcnt_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmco_pkg::REG_INDEX_MASK:   mask_r   <= cfg_data[IW-1:0];
        pmco_pkg::REG_COND_VALUE:   cond_r   <= cfg_data[IW-1:0];
        pmco_pkg::REG_OPERATION:    op_cfg_r <= pmco_pkg::op_t'(cfg_data[1:0]);
        pmco_pkg::REG_SUCCESS_REAL: sr_r     <= cfg_data;
        pmco_pkg::REG_SUCCESS_IMAG: si_r     <= cfg_data;
        pmco_pkg::REG_FAILURE_REAL: fr_r     <= cfg_data;
        pmco_pkg::REG_FAILURE_IMAG: fi_r     <= cfg_data;
        pmco_pkg::REG_QUBIT_COUNT:  qcnt_r   <= cfg_data[pmco_pkg::QCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // element position and coefficient choice
  assign r_cur    = in_start_of_matrix ? '0 : row_r;
  assign c_cur    = in_start_of_matrix ? '0 : col_r;
  assign q_eff    = (qcnt_r > 4'(pmco_pkg::MAX_QUB)) ? 4'(pmco_pkg::MAX_QUB) : qcnt_r;
  assign last_row = IW'((17'd1 << q_eff) - 17'd1);
  assign last_cur = (r_cur == last_row) && (c_cur == r_cur);
  assign hit      = ((r_cur & mask_r) == cond_r) && ((c_cur & mask_r) == cond_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.accept) begin
      if (last_cur) begin
        row_r <= '0;
        col_r <= '0;
      end else if (c_cur >= r_cur) begin
        row_r <= r_cur + 1'b1;
        col_r <= '0;
      end else begin
        col_r <= c_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ar_r      <= in_element_real;
      ai_r      <= in_element_imag;
      cr_r      <= hit ? sr_r : fr_r;
      ci_r      <= hit ? si_r : fi_r;
      czero_r   <= hit ? (sr_r == '0 && si_r == '0) : (fr_r == '0 && fi_r == '0);
      row_cur_r <= r_cur;
      col_cur_r <= c_cur;
      last_r    <= last_cur;
      op_r      <= op_cfg_r;
    end
  end

  // shared multiplier, one product a cycle
  always_comb begin
    unique case (cmd.mul_sel)
      3'd0:    begin ma = ar_r; mb = cr_r; end
      3'd1:    begin ma = ai_r; mb = ci_r; end
      3'd2:    begin ma = ar_r; mb = ci_r; end
      3'd3:    begin ma = ai_r; mb = cr_r; end
      3'd4:    begin ma = cr_r; mb = cr_r; end
      3'd5:    begin ma = ci_r; mb = ci_r; end
      default: begin ma = ar_r; mb = cr_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= ma * mb;
    psel_r <= cmd.mul_sel;
  end

  assign pe = AW'(p_r);

  // multiply: re = ar*cr - ai*ci, im = ar*ci + ai*cr
  // divide:   re = ar*cr + ai*ci, im = ai*cr - ar*ci, d = cr^2 + ci^2
  always_ff @(posedge clk) begin
    if (pv_r) begin
      unique case (psel_r)
        3'd0:    acc_re_r <= pe;
        3'd1:    acc_re_r <= (op_r == pmco_pkg::OP_MUL) ? acc_re_r - pe : acc_re_r + pe;
        3'd2:    acc_im_r <= (op_r == pmco_pkg::OP_MUL) ? pe : -pe;
        3'd3:    acc_im_r <= acc_im_r + pe;
        3'd4:    d_r      <= p_r[MW-1:0];
        3'd5:    d_r      <= d_r + p_r[MW-1:0];
        default: ;
      endcase
    end
  end

  // restoring dividers, one quotient bit a cycle for each part
  assign rem2_re = {rem_re_r, sh_re_r[MW-1]};
  assign rem2_im = {rem_im_r, sh_im_r[MW-1]};
  assign ge_re   = rem2_re >= {1'b0, d_r};
  assign ge_im   = rem2_im >= {1'b0, d_r};
  assign qn_re   = {q_re_r[QW-2:0], ge_re};
  assign qn_im   = {q_im_r[QW-2:0], ge_im};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_re_r <= acc_re_r[AW-1];
      neg_im_r <= acc_im_r[AW-1];
      sh_re_r  <= acc_re_r[AW-1] ? MW'(-acc_re_r) : acc_re_r[MW-1:0];
      sh_im_r  <= acc_im_r[AW-1] ? MW'(-acc_im_r) : acc_im_r[MW-1:0];
      rem_re_r <= '0;
      rem_im_r <= '0;
      q_re_r   <= '0;
      q_im_r   <= '0;
      big_re_r <= 1'b0;
      big_im_r <= 1'b0;
    end else if (cmd.div_step) begin
      sh_re_r  <= {sh_re_r[MW-2:0], 1'b0};
      sh_im_r  <= {sh_im_r[MW-2:0], 1'b0};
      rem_re_r <= ge_re ? MW'(rem2_re - {1'b0, d_r}) : rem2_re[MW-1:0];
      rem_im_r <= ge_im ? MW'(rem2_im - {1'b0, d_r}) : rem2_im[MW-1:0];
      if (!big_re_r) begin
        q_re_r   <= qn_re;
        big_re_r <= qn_re[QW-1];
      end
      if (!big_im_r) begin
        q_im_r   <= qn_im;
        big_im_r <= qn_im[QW-1];
      end
    end
  end

  // final rounding and saturation
  assign qr_re  = big_re_r ? (QW'(1) << 59) : QW'((q_re_r + 1'b1) >> 1);
  assign qr_im  = big_im_r ? (QW'(1) << 59) : QW'((q_im_r + 1'b1) >> 1);
  assign dv_re  = neg_re_r ? -AW'(qr_re) : AW'(qr_re);
  assign dv_im  = neg_im_r ? -AW'(qr_im) : AW'(qr_im);
  assign rnd_re = (acc_re_r + (AW'(1) <<< (pmco_pkg::FRAC_W - 1))) >>> pmco_pkg::FRAC_W;
  assign rnd_im = (acc_im_r + (AW'(1) <<< (pmco_pkg::FRAC_W - 1))) >>> pmco_pkg::FRAC_W;

  always_comb begin
    unique case (op_r)
      pmco_pkg::OP_ADD: begin
        x_re = AW'(ar_r) + AW'(cr_r);
        x_im = AW'(ai_r) + AW'(ci_r);
      end
      pmco_pkg::OP_SUB: begin
        x_re = AW'(ar_r) - AW'(cr_r);
        x_im = AW'(ai_r) - AW'(ci_r);
      end
      pmco_pkg::OP_MUL: begin
        x_re = rnd_re;
        x_im = rnd_im;
      end
      pmco_pkg::OP_DIV: begin
        x_re = czero_r ? '0 : dv_re;
        x_im = czero_r ? '0 : dv_im;
      end
      default: begin
        x_re = '0;
        x_im = '0;
      end
    endcase
  end

  assign s_re = pmco_pkg::sat_fn(x_re);
  assign s_im = pmco_pkg::sat_fn(x_im);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_real    <= s_re.val;
      out_result_imag    <= s_im.val;
      out_row_index      <= row_cur_r;
      out_col_index      <= col_cur_r;
      out_last_element   <= last_r;
      out_saturated      <= s_re.clip | s_im.clip;
      out_divide_by_zero <= (op_r == pmco_pkg::OP_DIV) && czero_r;
    end
  end

endmodule

/* hdl/packed_matrix_conditional_op_top.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | element real, imag, start of matrix
// out     | output    | out_valid / out_ready  | result real, imag, row, col, flags
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index (0..7), cfg_data
//
// one transaction in flight; add and subtract go from acceptance straight to
// finishing, multiply first forms 4 products through one 32x32 multiplier and
// divide forms 6 products, then 94 steps of a one-bit-per-cycle restoring divider
// a waiting result sits in the output register; the next transaction can be
// accepted while it waits, finishing stalls until out_ready frees the register
// synchronous active-low reset clears counters, control and configuration
// cfg_ready is always high
module packed_matrix_conditional_op_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pmco_pkg::DATA_W-1:0] in_element_real,
  input  logic signed [pmco_pkg::DATA_W-1:0] in_element_imag,
  input  logic                               in_start_of_matrix,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pmco_pkg::DATA_W-1:0] out_result_real,
  output logic signed [pmco_pkg::DATA_W-1:0] out_result_imag,
  output logic [pmco_pkg::IDX_W-1:0]         out_row_index,
  output logic [pmco_pkg::IDX_W-1:0]         out_col_index,
  output logic                               out_last_element,
  output logic                               out_saturated,
  output logic                               out_divide_by_zero,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pmco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmco_pkg::DATA_W-1:0]        cfg_data
);

  pmco_pkg::cmd_t  cmd;
  pmco_pkg::stat_t stat;

  pmco_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmco_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_element_real    (in_element_real),
    .in_element_imag    (in_element_imag),
    .in_start_of_matrix (in_start_of_matrix),
    .out_result_real    (out_result_real),
    .out_result_imag    (out_result_imag),
    .out_row_index      (out_row_index),
    .out_col_index      (out_col_index),
    .out_last_element   (out_last_element),
    .out_saturated      (out_saturated),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

/* tb/sv/packed_matrix_conditional_op_top_test.sv */
`timescale 1ns / 100ps

module packed_matrix_conditional_op_top_test;

  typedef struct {
    logic signed [pmco_pkg::DATA_W-1:0] re;
    logic signed [pmco_pkg::DATA_W-1:0] im;
    logic                               start;
  } element_t;

  typedef struct {
    logic signed [pmco_pkg::DATA_W-1:0] re;
    logic signed [pmco_pkg::DATA_W-1:0] im;
    logic [pmco_pkg::IDX_W-1:0]         row;
    logic [pmco_pkg::IDX_W-1:0]         col;
    logic                               last;
    logic                               sat;
    logic                               dz;
  } scaled_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [pmco_pkg::DATA_W-1:0] in_element_real = '0;
  logic signed [pmco_pkg::DATA_W-1:0] in_element_imag = '0;
  logic in_start_of_matrix = 1'b0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [pmco_pkg::DATA_W-1:0] out_result_real;
  logic signed [pmco_pkg::DATA_W-1:0] out_result_imag;
  logic [pmco_pkg::IDX_W-1:0] out_row_index;
  logic [pmco_pkg::IDX_W-1:0] out_col_index;
  logic out_last_element;
  logic out_saturated;
  logic out_divide_by_zero;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pmco_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pmco_pkg::DATA_W-1:0] cfg_data = '0;

  packed_matrix_conditional_op_top uut (.*);

  always #4 clk = ~clk;

  // shadow copy of the configuration and position counters
  logic [pmco_pkg::IDX_W-1:0] sh_mask, sh_cond, row_cnt, col_cnt;
  pmco_pkg::op_t sh_op;
  logic signed [pmco_pkg::DATA_W-1:0] sh_succ_re, sh_succ_im, sh_fail_re, sh_fail_im;
  logic [pmco_pkg::QCNT_W-1:0] sh_qubits;

  element_t pending_elems[$];
  scaled_t scaled_q[$];
  int errors = 0;
  int results_seen = 0;
  int in_gap = 0;
  int out_wait = 0;
  logic no_idle = 1'b0;
  longint cycles = 0;

  function automatic logic signed [67:0] sat_part(input logic signed [67:0] x,
                                                  inout logic clip);
    if (x > 68'sd2147483647) begin
      clip = 1'b1;
      return 68'sd2147483647;
    end
    if (x < -68'sd2147483648) begin
      clip = 1'b1;
      return -68'sd2147483648;
    end
    return x;
  endfunction

  function automatic logic signed [67:0] div_part(input logic signed [67:0] s,
                                                  input logic [63:0] d);
    logic [127:0] num, quo, mag;
    logic signed [67:0] v;
    mag = (s < 0) ? 128'(-s) : 128'(s);
    num = mag << 30;
    quo = num / {64'd0, d};
    if (quo >= (128'd1 << 60)) v = 68'sd1 <<< 59;
    else v = 68'((quo + 128'd1) >> 1);
    return (s < 0) ? -v : v;
  endfunction

  function automatic scaled_t scale_element(input element_t e);
    scaled_t res;
    logic [pmco_pkg::IDX_W-1:0] r, c, last_row;
    int q;
    logic hit, clip;
    longint ar, ai, cr, ci;
    logic signed [67:0] sr, si, rr, ri;
    logic [63:0] d;
    if (e.start) begin
      row_cnt = '0;
      col_cnt = '0;
    end
    r = row_cnt;
    c = col_cnt;
    q = (sh_qubits > pmco_pkg::MAX_QUB) ? pmco_pkg::MAX_QUB : int'(sh_qubits);
    last_row = pmco_pkg::IDX_W'((32'd1 << q) - 1);
    res.last = (r == last_row) && (c == r);
    if (res.last) begin
      row_cnt = '0;
      col_cnt = '0;
    end else if (c >= r) begin
      row_cnt = r + 1'b1;
      col_cnt = '0;
    end else begin
      col_cnt = c + 1'b1;
    end
    hit = ((r & sh_mask) == sh_cond) && ((c & sh_mask) == sh_cond);
    ar = e.re;
    ai = e.im;
    cr = hit ? sh_succ_re : sh_fail_re;
    ci = hit ? sh_succ_im : sh_fail_im;
    clip = 1'b0;
    res.dz = 1'b0;
    case (sh_op)
      pmco_pkg::OP_ADD: begin
        rr = ar + cr;
        ri = ai + ci;
      end
      pmco_pkg::OP_SUB: begin
        rr = ar - cr;
        ri = ai - ci;
      end
      pmco_pkg::OP_MUL: begin
        sr = ar * cr;
        sr = sr - ai * ci;
        si = ar * ci;
        si = si + ai * cr;
        rr = (sr + 68'sd268435456) >>> pmco_pkg::FRAC_W;
        ri = (si + 68'sd268435456) >>> pmco_pkg::FRAC_W;
      end
      default: begin
        if (cr == 0 && ci == 0) begin
          res.dz = 1'b1;
          rr = '0;
          ri = '0;
        end else begin
          d = 64'(cr * cr) + 64'(ci * ci);
          sr = ar * cr;
          sr = sr + ai * ci;
          si = ai * cr;
          si = si - ar * ci;
          rr = div_part(sr, d);
          ri = div_part(si, d);
        end
      end
    endcase
    rr = sat_part(rr, clip);
    ri = sat_part(ri, clip);
    res.re = rr[pmco_pkg::DATA_W-1:0];
    res.im = ri[pmco_pkg::DATA_W-1:0];
    res.row = r;
    res.col = c;
    res.sat = clip;
    return res;
  endfunction

  // input driver
  always @(posedge clk) begin
    logic busy;
    element_t e;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        e.re = in_element_real;
        e.im = in_element_imag;
        e.start = in_start_of_matrix;
        scaled_q.push_back(scale_element(e));
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_elems.size() > 0) begin
          e = pending_elems.pop_front();
          in_element_real <= e.re;
          in_element_imag <= e.im;
          in_start_of_matrix <= e.start;
          busy = 1'b1;
          in_gap <= no_idle ? 0 : int'($urandom_range(0, 6));
        end
      end
      in_valid <= busy;
    end
  end

  task automatic check_field(input string name, input logic [pmco_pkg::DATA_W-1:0] expv,
                             input logic [pmco_pkg::DATA_W-1:0] actv);
    if (expv !== actv) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, expv, actv);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    logic rdy;
    int w;
    scaled_t x;
    if (rst_n) begin
      rdy = out_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (scaled_q.size() == 0) begin
          $display("%0t unexpected result transaction", $time);
          errors++;
        end else begin
          x = scaled_q.pop_front();
          check_field("result_real", x.re, out_result_real);
          check_field("result_imag", x.im, out_result_imag);
          check_field("row_index", 32'(x.row), 32'(out_row_index));
          check_field("col_index", 32'(x.col), 32'(out_col_index));
          check_field("last_element", 32'(x.last), 32'(out_last_element));
          check_field("saturated", 32'(x.sat), 32'(out_saturated));
          check_field("divide_by_zero", 32'(x.dz), 32'(out_divide_by_zero));
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 400) w = 300;
        else w = no_idle ? 0 : int'($urandom_range(0, 6));
        rdy = (w == 0);
        out_wait <= w;
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        rdy = (out_wait == 1);
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("FAIL packed_matrix_conditional_op_top");
      $finish;
    end
  end

  task automatic write_reg(input logic [pmco_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmco_pkg::DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      pmco_pkg::REG_INDEX_MASK:   sh_mask = val[pmco_pkg::IDX_W-1:0];
      pmco_pkg::REG_COND_VALUE:   sh_cond = val[pmco_pkg::IDX_W-1:0];
      pmco_pkg::REG_OPERATION:    sh_op = pmco_pkg::op_t'(val[1:0]);
      pmco_pkg::REG_SUCCESS_REAL: sh_succ_re = val;
      pmco_pkg::REG_SUCCESS_IMAG: sh_succ_im = val;
      pmco_pkg::REG_FAILURE_REAL: sh_fail_re = val;
      pmco_pkg::REG_FAILURE_IMAG: sh_fail_im = val;
      default:                    sh_qubits = val[pmco_pkg::QCNT_W-1:0];
    endcase
  endtask

  task automatic configure(input logic [pmco_pkg::IDX_W-1:0] mask,
                           input logic [pmco_pkg::IDX_W-1:0] cond,
                           input pmco_pkg::op_t op, input logic [pmco_pkg::DATA_W-1:0] s_re,
                           input logic [pmco_pkg::DATA_W-1:0] s_im,
                           input logic [pmco_pkg::DATA_W-1:0] f_re,
                           input logic [pmco_pkg::DATA_W-1:0] f_im,
                           input logic [pmco_pkg::QCNT_W-1:0] qc);
    @(posedge clk);
    write_reg(pmco_pkg::REG_INDEX_MASK, 32'(mask));
    write_reg(pmco_pkg::REG_COND_VALUE, 32'(cond));
    write_reg(pmco_pkg::REG_OPERATION, 32'(op));
    write_reg(pmco_pkg::REG_SUCCESS_REAL, s_re);
    write_reg(pmco_pkg::REG_SUCCESS_IMAG, s_im);
    write_reg(pmco_pkg::REG_FAILURE_REAL, f_re);
    write_reg(pmco_pkg::REG_FAILURE_IMAG, f_im);
    write_reg(pmco_pkg::REG_QUBIT_COUNT, 32'(qc));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_elems.size() > 0 || in_valid || scaled_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [pmco_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return pmco_pkg::COEF_ONE;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_elem(input logic [pmco_pkg::DATA_W-1:0] re,
                           input logic [pmco_pkg::DATA_W-1:0] im, input logic start);
    element_t e;
    e.re = re;
    e.im = im;
    e.start = start;
    pending_elems.push_back(e);
  endtask

  initial begin
    logic [pmco_pkg::DATA_W-1:0] coef_re, coef_im;
    int n, qc;
    sh_mask = '0;
    sh_cond = '0;
    sh_op = pmco_pkg::OP_MUL;
    sh_succ_re = pmco_pkg::COEF_ONE;
    sh_succ_im = '0;
    sh_fail_re = pmco_pkg::COEF_ONE;
    sh_fail_im = '0;
    sh_qubits = '0;
    row_cnt = '0;
    col_cnt = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: every operation against extreme elements and coefficients
    for (int op = 0; op < 4; op++) begin
      // divide phase uses a zero failure coefficient
      configure(12'h001, 12'h001, pmco_pkg::op_t'(op), 32'h7FFF_FFFF, 32'h8000_0000,
                (op == 3) ? 32'h0 : pmco_pkg::COEF_ONE, 32'h0, 4'd2);
      push_elem(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      push_elem(32'h8000_0000, 32'h8000_0000, 1'b0);
      push_elem(32'h0, 32'h0, 1'b0);
      push_elem(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      push_elem(pmco_pkg::COEF_ONE, 32'hE000_0000, 1'b0);
      push_elem($urandom, $urandom, 1'b0);
      drain();
    end
    // condition bits outside the mask, oversize qubit count
    configure(12'h00F, 12'h0F0, pmco_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1,
              32'h1, 4'd15);
    for (int i = 0; i < 4; i++) push_elem($urandom, $urandom, i == 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      qc = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 15))
                                       : int'($urandom_range(0, 4));
      coef_re = pick_word();
      coef_im = ($urandom_range(0, 3) == 0) ? 32'h0 : pick_word();
      configure(($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7)),
                ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3)),
                pmco_pkg::op_t'($urandom_range(0, 3)), coef_re, coef_im, pick_word(),
                ($urandom_range(0, 3) == 0) ? 32'h0 : pick_word(), 4'(qc));
      no_idle <= (ph % 4 == 3);
      n = 0;
      while (n < 100) begin
        int len;
        // mostly whole matrices opened by a start flag, some stray restarts
        len = (qc <= 4) ? (1 << qc) * ((1 << qc) + 1) / 2 : int'($urandom_range(5, 40));
        for (int i = 0; i < len && n < 100; i++) begin
          push_elem(($urandom_range(0, 9) == 0) ? pick_word() : $urandom,
                    ($urandom_range(0, 9) == 0) ? pick_word() : $urandom,
                    (i == 0) || ($urandom_range(0, 30) == 0));
          n++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS packed_matrix_conditional_op_top");
    end else begin
      $display("FAIL packed_matrix_conditional_op_top");
    end
    $finish;
  end

endmodule
